// File: hdl/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
`default_nettype none
package rau_pkg;

  localparam int unsigned PartW = 32;
  localparam int unsigned WideW = 64;
  localparam int unsigned KindW = 3;

  typedef enum logic [KindW-1:0] {
    KIND_ADD = 3'd0,
    KIND_SUB = 3'd1,
    KIND_MUL = 3'd2,
    KIND_DIV = 3'd3,
    KIND_NEG = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_GCD,
    ST_GSHIFT,
    ST_NGO,
    ST_NWAIT,
    ST_DGO,
    ST_DWAIT,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// File: hdl/rau_div.sv
// Restoring 64-bit unsigned divider, one quotient bit per cycle.
`default_nettype none
module rau_div
  import rau_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [WideW-1:0] dividend,
  input  wire logic [WideW-1:0] divisor,
  output logic                  done,
  output logic [WideW-1:0]      quotient
);

  localparam int unsigned CntW = $clog2(WideW + 1);

  logic [WideW-1:0] rem;
  logic [WideW-1:0] dvs;
  logic [CntW-1:0]  cnt;
  logic             busy;
  logic [WideW:0]   trial;
  logic             fits;

  assign trial = {rem, quotient[WideW-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(WideW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      // shift in the next dividend bit, subtract when the divisor fits
      if (fits) begin
        rem <= WideW'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[WideW-1:0];
      end
      quotient <= {quotient[WideW-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// File: hdl/rational_arith_unit_core.sv
// Top level of the rational arithmetic unit: sequencer, multiplier, gcd and divide.
//
//  channel | dir | beat contents
//  --------+-----+----------------------------------------------------------
//  s_axis  | in  | tuser: kind; tdata: a_num, a_den, b_num, b_den
//  m_axis  | out | tdata: res_num, res_den, div_zero, compare flags
//
// One item at a time. The products are formed in turn on one 32x32 multiplier,
// the raw fraction is built, then a binary gcd loop runs (one subtract or
// shift per cycle), the common power of two is shifted back, and two
// divisions run on one shared divider. Negate, a zero denominator and the
// unused kinds go from the raw fraction straight to the result.
// s_tready is high only while idle; the result holds on m_axis until taken.
// rst is synchronous and returns the sequencer to idle.
`default_nettype none
module rational_arith_unit_core
  import rau_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [127:0] s_tdata,   // a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96]
  input  wire logic [2:0]   s_tuser,   // kind[2:0]
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [135:0]      m_tdata    // res_num[63:0], res_den[127:64], div_zero[128],
                                       // less[129], less_equal[130], greater[131],
                                       // greater_equal[132], equal[133], zero pad
);

  localparam int unsigned ShW = $clog2(WideW);

  state_t state, state_next;

  // captured operands
  logic [KindW-1:0]        kind;
  logic signed [PartW-1:0] an, ad, bn, bd;

  // products: lhs = an*bd, rhs = ad*bn, dd = ad*bd, nn = an*bn
  logic [1:0]              mcnt;
  logic signed [PartW-1:0] op_a, op_b;
  logic signed [WideW-1:0] lhs, rhs, dd, nn;

  // raw fraction in sign-magnitude
  logic signed [WideW:0]   raw_n;
  logic signed [WideW-1:0] raw_d;
  logic [WideW-1:0]        nmag_c, dmag_c;
  logic [WideW-1:0]        nmag, dmag;
  logic                    nneg;

  // gcd
  logic [WideW-1:0] gx, gy;
  logic [ShW-1:0]   kpow;

  // divider
  logic             div_start;
  logic             div_done;
  logic [WideW-1:0] div_q;
  logic [WideW-1:0] qn;

  // result
  logic [WideW-1:0] res_num, res_den;
  logic             div_zero;

  rau_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ((state == ST_NGO) ? nmag : dmag),
    .divisor  (gx),
    .done     (div_done),
    .quotient (div_q)
  );

  // operand select for the shared multiplier
  always_comb begin
    unique case (mcnt)
      2'd0:    begin op_a = an; op_b = bd; end
      2'd1:    begin op_a = ad; op_b = bn; end
      2'd2:    begin op_a = ad; op_b = bd; end
      default: begin op_a = an; op_b = bn; end
    endcase
  end

  // raw numerator exact at 65 bits, raw denominator exact at 64 bits
  always_comb begin
    unique case (kind)
      KIND_ADD: raw_n = {lhs[WideW-1], lhs} + {rhs[WideW-1], rhs};
      KIND_SUB: raw_n = {lhs[WideW-1], lhs} - {rhs[WideW-1], rhs};
      KIND_MUL: raw_n = {nn[WideW-1], nn};
      default:  raw_n = {lhs[WideW-1], lhs};
    endcase
    raw_d  = (kind == KIND_DIV) ? rhs : dd;
    nmag_c = raw_n[WideW] ? WideW'(-raw_n) : raw_n[WideW-1:0];
    dmag_c = raw_d[WideW-1] ? WideW'(-raw_d) : raw_d;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_MUL;
      ST_MUL:    if (mcnt == 2'd3) state_next = ST_PREP;
      ST_PREP: begin
        if (kind > KIND_DIV || dmag_c == '0) state_next = ST_DONE;
        else state_next = ST_GCD;
      end
      ST_GCD:    if (gx == '0 || gy == '0) state_next = ST_GSHIFT;
      ST_GSHIFT: if (kpow == '0) state_next = ST_NGO;
      ST_NGO:    state_next = ST_NWAIT;
      ST_NWAIT:  if (div_done) state_next = ST_DGO;
      ST_DGO:    state_next = ST_DWAIT;
      ST_DWAIT:  if (div_done) state_next = ST_DONE;
      ST_DONE:   if (m_tready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // handshake and divider strobes
  always_comb begin
    s_tready  = (state == ST_IDLE);
    m_tvalid  = (state == ST_DONE);
    div_start = (state == ST_NGO) || (state == ST_DGO);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      mcnt  <= '0;
    end else begin
      state <= state_next;
      if (state == ST_MUL) mcnt <= mcnt + 1'b1;
      else mcnt <= '0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          kind <= s_tuser;
          an   <= s_tdata[31:0];
          ad   <= s_tdata[63:32];
          bn   <= s_tdata[95:64];
          bd   <= s_tdata[127:96];
        end
      end
      ST_MUL: begin
        unique case (mcnt)
          2'd0:    lhs <= op_a * op_b;
          2'd1:    rhs <= op_a * op_b;
          2'd2:    dd  <= op_a * op_b;
          default: nn  <= op_a * op_b;
        endcase
      end
      ST_PREP: begin
        nmag <= nmag_c;
        dmag <= dmag_c;
        nneg <= raw_n[WideW] ^ raw_d[WideW-1];
        gx   <= nmag_c;
        gy   <= dmag_c;
        kpow <= '0;
        if (kind == KIND_NEG) begin
          res_num  <= -WideW'(an);
          res_den  <= WideW'(ad);
          div_zero <= (ad == '0);
        end else if (kind > KIND_NEG) begin
          res_num  <= '0;
          res_den  <= '0;
          div_zero <= 1'b0;
        end else begin
          // zero denominator: report the sign of the numerator over zero
          div_zero <= (dmag_c == '0);
          res_den  <= '0;
          if (nmag_c == '0) res_num <= '0;
          else if (raw_n[WideW] ^ raw_d[WideW-1]) res_num <= '1;
          else res_num <= WideW'(1);
        end
      end
      ST_GCD: begin
        priority if (gx == '0) begin
          gx <= gy;
        end else if (gy == '0) begin
          gx <= gx;
        end else if (!gx[0] && !gy[0]) begin
          gx   <= gx >> 1;
          gy   <= gy >> 1;
          kpow <= kpow + 1'b1;
        end else if (!gx[0]) begin
          gx <= gx >> 1;
        end else if (!gy[0]) begin
          gy <= gy >> 1;
        end else if (gx >= gy) begin
          gx <= gx - gy;
        end else begin
          gy <= gy - gx;
        end
      end
      ST_GSHIFT: begin
        // restore the common power of two
        if (kpow != '0) begin
          gx   <= gx << 1;
          kpow <= kpow - 1'b1;
        end
      end
      ST_NWAIT: if (div_done) qn <= div_q;
      ST_DWAIT: begin
        if (div_done) begin
          res_den <= div_q;
          res_num <= nneg ? -qn : qn;
        end
      end
      default: ;
    endcase
  end

  assign m_tdata = {2'b00,
                    lhs == rhs,
                    lhs >= rhs,
                    lhs > rhs,
                    lhs <= rhs,
                    lhs < rhs,
                    div_zero,
                    res_den,
                    res_num};

endmodule
`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the rational arithmetic unit core.
`default_nettype none
module testbench
  import rau_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [63:0] res_num;
    logic [63:0] res_den;
    logic        div_zero;
    logic        less;
    logic        less_equal;
    logic        greater;
    logic        greater_equal;
    logic        equal;
  } fraction_result_t;

  localparam int unsigned StallLimit = 20000;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;
  logic [2:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [135:0] m_tdata;

  fraction_result_t expected_fractions[$];
  int unsigned      mismatches;
  int unsigned      results_seen;
  int unsigned      items_sent;
  bit               calm_stretch;
  bit               test_done;

  rational_arith_unit_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Euclid on magnitudes.
  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Compute the expected result of one item.
  function automatic fraction_result_t reduce_fraction(logic [2:0] kind,
      logic signed [31:0] an, logic signed [31:0] ad,
      logic signed [31:0] bn, logic signed [31:0] bd);
    fraction_result_t r;
    logic signed [63:0] lhs, rhs, raw_d;
    logic [63:0] raw_n, nmag, dmag, g;
    bit nneg, dneg;
    lhs = 64'(an) * 64'(bd);
    rhs = 64'(ad) * 64'(bn);
    r = '0;
    if (kind <= KIND_DIV) begin
      raw_d = 64'(ad) * 64'(bd);
      case (kind)
        KIND_ADD: raw_n = lhs + rhs;
        KIND_SUB: raw_n = lhs - rhs;
        KIND_MUL: raw_n = 64'(an) * 64'(bn);
        default: begin
          raw_n = lhs;
          raw_d = rhs;
        end
      endcase
      // 2^63 only arises from adding, and is positive.
      nneg = raw_n[63] && (raw_n != 64'h8000_0000_0000_0000);
      nmag = nneg ? -raw_n : raw_n;
      dneg = raw_d < 0;
      dmag = dneg ? -raw_d : raw_d;
      if (dneg) nneg = !nneg;
      if (dmag == 0) begin
        r.div_zero = 1'b1;
        r.res_num = (nmag == 0) ? 64'd0 : (nneg ? '1 : 64'd1);
      end else begin
        g = gcd64(nmag, dmag);
        nmag = nmag / g;
        r.res_num = nneg ? -nmag : nmag;
        r.res_den = dmag / g;
      end
    end else if (kind == KIND_NEG) begin
      r.res_num = -64'(an);
      r.res_den = 64'(ad);
      r.div_zero = (ad == 0);
    end
    r.less = lhs < rhs;
    r.less_equal = lhs <= rhs;
    r.greater = lhs > rhs;
    r.greater_equal = lhs >= rhs;
    r.equal = lhs == rhs;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    mismatches++;
  endtask

  // Send one beat; random idle before it unless in a calm stretch.
  // tvalid stays high after the accepting edge until the next idle or beat.
  task automatic send_fraction_pair(logic [2:0] kind, logic [31:0] an, logic [31:0] ad,
      logic [31:0] bn, logic [31:0] bd);
    while (!calm_stretch && $urandom_range(99) < 16) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {bd, bn, ad, an};
    expected_fractions.push_back(reduce_fraction(kind, an, ad, bn, bd));
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  function automatic logic [31:0] pick_part();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'd0;
      3: return 32'($signed($urandom_range(20)) - 10);
      4: return 32'hFFFF_FFFF;
      5, 6: return 32'($urandom_range(1000)) * (($urandom & 1) ? 1 : -1);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_kind();
    return ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
  endfunction

  // Drop tvalid and hold off until every expected result has come.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_fractions.size() != 0) @(posedge clk);
  endtask

  // Directed: extremes, each operation, zero denominators, the 2^63 sum.
  task automatic test_directed();
    logic [31:0] mn;
    mn = 32'h8000_0000;
    send_fraction_pair(KIND_ADD, mn, mn, mn, mn);
    send_fraction_pair(KIND_SUB, mn, mn, mn, mn);
    send_fraction_pair(KIND_MUL, mn, mn, mn, mn);
    send_fraction_pair(KIND_DIV, mn, mn, mn, mn);
    send_fraction_pair(KIND_NEG, mn, mn, 0, 1);
    send_fraction_pair(KIND_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, mn);
    send_fraction_pair(KIND_ADD, 1, 2, 1, 3);
    send_fraction_pair(KIND_SUB, 1, 2, 1, 2);
    send_fraction_pair(KIND_MUL, 2, -3, 3, 4);
    send_fraction_pair(KIND_DIV, 2, 3, 0, 5);
    send_fraction_pair(KIND_DIV, -2, 3, 0, 5);
    send_fraction_pair(KIND_ADD, 5, 0, 1, 2);
    send_fraction_pair(KIND_ADD, 0, 0, 0, 0);
    send_fraction_pair(KIND_MUL, -5, 3, 1, 0);
    send_fraction_pair(KIND_NEG, 7, 0, 1, 1);
    send_fraction_pair(KIND_NEG, 7, -3, 1, 1);
    send_fraction_pair(KIND_MUL, 0, 7, 3, 9);
    send_fraction_pair(3'd5, 1, 2, 3, 4);
    send_fraction_pair(3'd7, '1, '1, '1, '1);
    send_fraction_pair(KIND_DIV, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 1);
  endtask

  task automatic test_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      calm_stretch = (i >= count / 3) && (i < count / 3 + 200);
      send_fraction_pair(pick_kind(), pick_part(), pick_part(), pick_part(), pick_part());
      // Hold off once until the unit has fully drained.
      if (i == count / 2) drain_results();
    end
    calm_stretch = 1'b0;
  endtask

  // Check each result beat against the oldest expectation.
  always @(posedge clk) begin
    fraction_result_t got, want;
    if (!rst) begin
      m_tready <= calm_stretch || ($urandom_range(99) >= 16);
      if (m_tvalid && m_tready) begin
        got.res_num       = m_tdata[63:0];
        got.res_den       = m_tdata[127:64];
        got.div_zero      = m_tdata[128];
        got.less          = m_tdata[129];
        got.less_equal    = m_tdata[130];
        got.greater       = m_tdata[131];
        got.greater_equal = m_tdata[132];
        got.equal         = m_tdata[133];
        results_seen++;
        if (expected_fractions.size() == 0) begin
          report_mismatch("unexpected beat", m_tdata[63:0], 64'd0);
        end else begin
          want = expected_fractions.pop_front();
          if (got.res_num != want.res_num) report_mismatch("res_num", got.res_num, want.res_num);
          if (got.res_den != want.res_den) report_mismatch("res_den", got.res_den, want.res_den);
          if (got[5:0] != want[5:0]) report_mismatch("flags", 64'(got[5:0]), 64'(want[5:0]));
        end
      end
    end
  end

  // Watchdog: cycles with no beat on either side.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (!test_done) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
      if (quiet >= StallLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    mismatches = 0;
    results_seen = 0;
    items_sent = 0;
    calm_stretch = 1'b0;
    test_done = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(1630);
    drain_results();
    repeat (500) @(posedge clk);
    test_done = 1'b1;
    $display("sent %0d items, checked %0d results", items_sent, results_seen);
    $display("covered all kinds, extreme parts, zero denominators and unused kinds");
    if (mismatches == 0 && expected_fractions.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
